[src/vn4d_pkg.sv]
// Shared constants and types for the 4D value noise core.
package vn4d_pkg;
   localparam int TABLE_SIZE = 256;
   localparam int TBL_BITS   = $clog2(TABLE_SIZE);
   localparam int FRAC_BITS  = 16;
   localparam int VAL_W      = 16;
   localparam int PERM_W     = 8;
   localparam int IDX_W      = 8;
   localparam int COORD_W    = 32;
   localparam int CORNER_W   = 3;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef logic [TBL_BITS-1:0]     tbl_addr_type;
   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [FRAC_BITS-1:0]    frac_type;

   typedef struct packed {
      logic                valid;
      logic [CORNER_W-1:0] corner;
      val_type             v0;
      val_type             v1;
   } vn4d_pair_type;
endpackage

[src/vn4d_if.sv]
// Request and response channel interfaces.
interface vn4d_req_if;
   import vn4d_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [IDX_W-1:0]          entry_index;
   logic signed [VAL_W-1:0]   noise_entry;
   logic [PERM_W-1:0]         perm_entry;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;
   logic signed [COORD_W-1:0] coord_z;
   logic signed [COORD_W-1:0] coord_t;
   modport source (output valid, cmd, entry_index, noise_entry, perm_entry,
                   coord_x, coord_y, coord_z, coord_t, input ready);
   modport sink (input valid, cmd, entry_index, noise_entry, perm_entry,
                 coord_x, coord_y, coord_z, coord_t, output ready);
endinterface

interface vn4d_rsp_if;
   import vn4d_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] noise_out;
   modport source (output valid, noise_out, input ready);
   modport sink (input valid, noise_out, output ready);
endinterface

[src/vn4d_ram.sv]
// Generic RAM: one write port, two registered read ports.
module vn4d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

[src/vn4d_fetch.sv]
// Table storage and corner hash sequencer: chained permutation reads per corner pair.
module vn4d_fetch (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  vn4d_pkg::tbl_addr_type load_addr,
   input  vn4d_pkg::val_type      load_value,
   input  logic [vn4d_pkg::PERM_W-1:0] load_perm,
   input  logic                   start,
   input  vn4d_pkg::tbl_addr_type lat_x,
   input  vn4d_pkg::tbl_addr_type lat_y,
   input  vn4d_pkg::tbl_addr_type lat_z,
   input  vn4d_pkg::tbl_addr_type lat_t,
   output vn4d_pkg::vn4d_pair_type pair,
   output logic                   busy
);
   import vn4d_pkg::*;

   localparam logic [1:0] PH_T = 2'd0;
   localparam logic [1:0] PH_Z = 2'd1;
   localparam logic [1:0] PH_Y = 2'd2;
   localparam logic [1:0] PH_X = 2'd3;
   localparam logic [CORNER_W-1:0] LAST_PAIR = '1;

   logic                busy_ff, busy_in;
   logic [1:0]          phase_ff, phase_in;
   logic [CORNER_W-1:0] pair_ff, pair_in;
   tbl_addr_type        ix_ff, iy_ff, iz_ff, it_ff;
   logic                p3_ff;
   logic [CORNER_W-1:0] p3pair_ff;
   logic                vdv_ff;
   logic [CORNER_W-1:0] vdpair_ff;

   tbl_addr_type        perm_addr_a, perm_addr_b;
   logic [PERM_W-1:0]   perm_a, perm_b;
   tbl_addr_type        val_addr_a, val_addr_b;
   val_type             val_a, val_b;
   tbl_addr_type        perm_off;

   assign perm_off = TBL_BITS'(perm_a);

   always_comb begin
      unique case (phase_ff)
         PH_T: perm_addr_a = it_ff + TBL_BITS'(pair_ff[2]);
         PH_Z: perm_addr_a = iz_ff + TBL_BITS'(pair_ff[1]) + perm_off;
         PH_Y: perm_addr_a = iy_ff + TBL_BITS'(pair_ff[0]) + perm_off;
         PH_X: perm_addr_a = ix_ff + perm_off;
         default: perm_addr_a = ix_ff;
      endcase
      perm_addr_b = ix_ff + TBL_BITS'(1) + perm_off;
      val_addr_a  = TBL_BITS'(perm_a);
      val_addr_b  = TBL_BITS'(perm_b);
   end

   vn4d_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm_ram (
      .clock     (clock),
      .wr_en     (load),
      .wr_addr   (load_addr),
      .wr_data   (load_perm),
      .rd_addr_a (perm_addr_a),
      .rd_data_a (perm_a),
      .rd_addr_b (perm_addr_b),
      .rd_data_b (perm_b)
   );

   vn4d_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SIZE)) u_value_ram (
      .clock     (clock),
      .wr_en     (load),
      .wr_addr   (load_addr),
      .wr_data   (load_value),
      .rd_addr_a (val_addr_a),
      .rd_data_a (val_a),
      .rd_addr_b (val_addr_b),
      .rd_data_b (val_b)
   );

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      pair_in  = pair_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = PH_T;
         pair_in  = '0;
      end else if (busy_ff) begin
         phase_in = phase_ff + 2'd1;
         if (phase_ff == PH_X) begin
            pair_in = pair_ff + CORNER_W'(1);
            if (pair_ff == LAST_PAIR) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         p3_ff   <= 1'b0;
         vdv_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         p3_ff   <= busy_ff && (phase_ff == PH_X);
         vdv_ff  <= p3_ff;
      end
      phase_ff  <= phase_in;
      pair_ff   <= pair_in;
      p3pair_ff <= pair_ff;
      vdpair_ff <= p3pair_ff;
      if (start) begin
         ix_ff <= lat_x;
         iy_ff <= lat_y;
         iz_ff <= lat_z;
         it_ff <= lat_t;
      end
   end

   assign pair.valid  = vdv_ff;
   assign pair.corner = vdpair_ff;
   assign pair.v0     = val_a;
   assign pair.v1     = val_b;
   assign busy        = busy_ff | p3_ff | vdv_ff;
endmodule

[src/vn4d_blend.sv]
// Quadrilinear blend: one shared lerp unit stepped through the x, y, z, t levels.
module vn4d_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  vn4d_pkg::frac_type      frac_x,
   input  vn4d_pkg::frac_type      frac_y,
   input  vn4d_pkg::frac_type      frac_z,
   input  vn4d_pkg::frac_type      frac_t,
   input  vn4d_pkg::vn4d_pair_type pair,
   input  logic                    out_free,
   output logic                    res_valid,
   output vn4d_pkg::val_type       res_value,
   output logic                    busy
);
   import vn4d_pkg::*;

   localparam logic [1:0] LVL_X = 2'd0;
   localparam logic [1:0] LVL_Y = 2'd1;
   localparam logic [1:0] LVL_Z = 2'd2;
   localparam logic [1:0] LVL_T = 2'd3;
   localparam int PROD_W = VAL_W + FRAC_BITS + 2;

   frac_type            wx_ff, wy_ff, wz_ff, wt_ff;
   val_type             a_ff, b_ff;
   val_type             y0_ff, z0_ff, t0_ff;
   logic [1:0]          lvl_ff;
   logic [CORNER_W-1:0] bits_ff;
   logic                act_ff;

   frac_type                 w_sel;
   logic signed [VAL_W:0]    diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] rounded;
   logic signed [PROD_W-1:0] quot;
   val_type                  lerp_r;
   logic                     fire;

   always_comb begin
      unique case (lvl_ff)
         LVL_X: w_sel = wx_ff;
         LVL_Y: w_sel = wy_ff;
         LVL_Z: w_sel = wz_ff;
         LVL_T: w_sel = wt_ff;
         default: w_sel = wx_ff;
      endcase
      diff    = {b_ff[VAL_W-1], b_ff} - {a_ff[VAL_W-1], a_ff};
      prod    = PROD_W'(diff) * $signed({2'b00, w_sel});
      rounded = prod + PROD_W'(1 << (FRAC_BITS - 1));
      quot    = rounded >>> FRAC_BITS;
      lerp_r  = a_ff + quot[VAL_W-1:0];
      fire    = act_ff && ((lvl_ff != LVL_T) || out_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else if (pair.valid) begin
         act_ff <= 1'b1;
      end else if (fire) begin
         act_ff <= (lvl_ff != LVL_T) && bits_ff[lvl_ff];
      end
      if (start) begin
         wx_ff <= frac_x;
         wy_ff <= frac_y;
         wz_ff <= frac_z;
         wt_ff <= frac_t;
      end
      if (pair.valid) begin
         a_ff    <= pair.v0;
         b_ff    <= pair.v1;
         lvl_ff  <= LVL_X;
         bits_ff <= pair.corner;
      end else if (fire) begin
         b_ff   <= lerp_r;
         lvl_ff <= lvl_ff + 2'd1;
         unique case (lvl_ff)
            LVL_X: begin
               if (bits_ff[0]) a_ff <= y0_ff;
               else y0_ff <= lerp_r;
            end
            LVL_Y: begin
               if (bits_ff[1]) a_ff <= z0_ff;
               else z0_ff <= lerp_r;
            end
            LVL_Z: begin
               if (bits_ff[2]) a_ff <= t0_ff;
               else t0_ff <= lerp_r;
            end
            default: a_ff <= a_ff;
         endcase
      end
   end

   assign res_valid = fire && (lvl_ff == LVL_T);
   assign res_value = lerp_r;
   assign busy      = act_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      pair.valid |-> !act_ff) else $error("corner pair arrived while blend busy");
   a_last_pair: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (bits_ff == '1)) else $error("result from a pair other than the last");
   a_act_src: assert property (@(posedge clock) disable iff (reset)
      $rose(act_ff) |-> $past(pair.valid)) else $error("blend started without a pair");
endmodule

[src/value_noise_4d_core.sv]
// Top level: 4D lattice value noise core with table loading.
// Load transfer: tables are written at the transfer edge.
// Query: no new request is accepted until the result has moved into the response
// register. Query time is set by chained t, z, y, x reads of the permutation RAM for
// each of 8 corner pairs, plus value read and the serial lerp levels of the last pair.
// Reset clears handshake and sequencer control only; table contents are kept.
module value_noise_4d_core (
   input logic       clock,
   input logic       reset,
   vn4d_req_if.sink  req_chan,
   vn4d_rsp_if.source rsp_chan
);
   import vn4d_pkg::*;

   logic          fetch_busy, blend_busy;
   logic          xfer, load, start;
   vn4d_pair_type pair;
   logic          res_valid;
   val_type       res_value;
   logic          out_free;
   logic          rsp_valid_ff;
   val_type       rsp_data_ff;

   assign req_chan.ready = !fetch_busy && !blend_busy;
   assign xfer           = req_chan.valid && req_chan.ready;
   assign load           = xfer && (req_chan.cmd == CMD_LOAD);
   assign start          = xfer && (req_chan.cmd == CMD_QUERY);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   vn4d_fetch u_fetch (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_addr  (TBL_BITS'(req_chan.entry_index)),
      .load_value (req_chan.noise_entry),
      .load_perm  (req_chan.perm_entry),
      .start      (start),
      .lat_x      (req_chan.coord_x[FRAC_BITS +: TBL_BITS]),
      .lat_y      (req_chan.coord_y[FRAC_BITS +: TBL_BITS]),
      .lat_z      (req_chan.coord_z[FRAC_BITS +: TBL_BITS]),
      .lat_t      (req_chan.coord_t[FRAC_BITS +: TBL_BITS]),
      .pair       (pair),
      .busy       (fetch_busy)
   );

   vn4d_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .frac_x    (req_chan.coord_x[FRAC_BITS-1:0]),
      .frac_y    (req_chan.coord_y[FRAC_BITS-1:0]),
      .frac_z    (req_chan.coord_z[FRAC_BITS-1:0]),
      .frac_t    (req_chan.coord_t[FRAC_BITS-1:0]),
      .pair      (pair),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res_value (res_value),
      .busy      (blend_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid) begin
         rsp_data_ff <= res_value;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.noise_out = rsp_data_ff;
endmodule
